// File: design/dur_pkg.sv
// Shared types, register codes and lookup functions for the dual UART register model.
// Used by dual_uart_register_model; depends on nothing else.
package dur_pkg;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_TX_DONE = 3'd2,
    CMD_RX_BYTE = 3'd3,
    CMD_INT_ACK = 3'd4
  } cmd_t;

  // Status register bits.
  localparam logic [3:0] ST_RXRDY = 4'h1;
  localparam logic [3:0] ST_FFULL = 4'h2;
  localparam logic [3:0] ST_TXRDY = 4'h4;
  localparam logic [3:0] ST_TXEMT = 4'h8;
  localparam logic [3:0] ST_RX_BITS = ST_RXRDY | ST_FFULL;
  localparam logic [3:0] ST_TX_BITS = ST_TXRDY | ST_TXEMT;

  // Bus register numbers and per-channel sub-addresses.
  localparam logic [3:0] REG_ISR_IMR = 4'd5;
  localparam logic [3:0] REG_IVR     = 4'd12;
  localparam logic [2:0] SUB_MODE    = 3'd0;
  localparam logic [2:0] SUB_STATUS  = 3'd1;
  localparam logic [2:0] SUB_COMMAND = 3'd2;
  localparam logic [2:0] SUB_BUFFER  = 3'd3;

  // Command register fields.
  localparam logic [2:0] MISC_RESET_PTR = 3'd1;
  localparam logic [2:0] MISC_RESET_RX  = 3'd2;
  localparam logic [2:0] MISC_RESET_TX  = 3'd3;
  localparam logic [1:0] XC_ENABLE      = 2'd1;
  localparam logic [1:0] XC_DISABLE     = 2'd2;

  localparam logic [1:0] MODE_AUTO_ECHO = 2'b01;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LEVEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAUD_SET  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_A    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_B    = 8'd3;

  localparam int unsigned DELAY_W = 18;
  localparam logic [DELAY_W-1:0] RX_RETRY_US = 18'd50000;
  localparam logic [7:0] SPURIOUS_VEC = 8'd24;

  function automatic logic [DELAY_W-1:0] baud_delay_f(input logic set_sel,
                                                       input logic [3:0] nib);
    logic [DELAY_W-1:0] d;
    case ({set_sel, nib})
      5'd0:  d = 18'd160000;
      5'd1:  d = 18'd72727;
      5'd2:  d = 18'd59479;
      5'd3:  d = 18'd40000;
      5'd4:  d = 18'd26666;
      5'd5:  d = 18'd13333;
      5'd6:  d = 18'd6666;
      5'd7:  d = 18'd7619;
      5'd8:  d = 18'd3333;
      5'd9:  d = 18'd1666;
      5'd10: d = 18'd1111;
      5'd11: d = 18'd833;
      5'd12: d = 18'd208;
      5'd16: d = 18'd106666;
      5'd17: d = 18'd72727;
      5'd18: d = 18'd59479;
      5'd19: d = 18'd53333;
      5'd20: d = 18'd26666;
      5'd21: d = 18'd13333;
      5'd22: d = 18'd6666;
      5'd23: d = 18'd4000;
      5'd24: d = 18'd3333;
      5'd25: d = 18'd1666;
      5'd26: d = 18'd4444;
      5'd27: d = 18'd833;
      5'd28: d = 18'd416;
      default: d = 18'd1666;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] char_mask_f(input logic [1:0] len, input logic [7:0] v);
    logic [7:0] m;
    case (len)
      2'd0:    m = 8'h1f;
      2'd1:    m = 8'h3f;
      2'd2:    m = 8'h7f;
      default: m = 8'hff;
    endcase
    return v & m;
  endfunction

  // Interrupt status from the status of channel ch (st_c) and of the other channel (st_o).
  function automatic logic [7:0] int_status_f(input logic ch,
                                              input logic [3:0] st_c, input logic ff_c,
                                              input logic [3:0] st_o, input logic ff_o);
    logic [3:0] st_a, st_b;
    logic       ff_a, ff_b;
    logic [7:0] s;
    st_a = ch ? st_o : st_c;
    st_b = ch ? st_c : st_o;
    ff_a = ch ? ff_o : ff_c;
    ff_b = ch ? ff_c : ff_o;
    s = 8'h00;
    s[0] = st_a[2];
    s[1] = ff_a ? st_a[1] : st_a[0];
    s[4] = st_b[2];
    s[5] = ff_b ? st_b[1] : st_b[0];
    return s;
  endfunction

endpackage

// File: design/dual_uart_register_model.sv
// Top level of the dual UART register model: bus register file, line events, interrupts.
// Depends on dur_pkg for command codes, register numbers and the baud delay table.
//
// Usage: each input beat carries one item (bus read, bus write, transmit done, receive
// byte or interrupt acknowledge; the command code travels in in_tuser). Every item
// yields exactly one result beat on the out_ channel with read data, the transmitted
// byte, the receive acceptance, a next-event delay, the interrupt request and the
// acknowledge vector.
// The result is registered at the edge that accepts the item.
// Throughput is one item per cycle while out_tready is high; the only limit is the single result register.
// When the receiver stalls, the result register holds its beat and in_tready stays
// high only if out_tready is high in that cycle, so nothing is lost or repeated.
// Configuration beats are accepted in every cycle and take effect for the next item.
// Reset clears all channel state but the mode pointers, which it sets, clears the
// interrupt mask and pending flag, sets the interrupt vector to 0x0f and the
// configuration to level 1, first baud set, both lines present.
module dual_uart_register_model
  import dur_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Fields from bit 0: channel[0], reg_index[4:1], write_data[12:5], rx_data[20:13].
  input  logic [23:0]          in_tdata,
  // Fields from bit 0: command[2:0].
  input  logic [2:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // Fields from bit 0: read_data[7:0], tx_valid[8], tx_data[16:9], rx_accepted[17],
  // delay_valid[18], delay_us[36:19], irq_request[37], ack_vector[45:38].
  output logic [47:0]          out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [2:0] int_level_r;
  logic       baud_set_r, port_a_r, port_b_r;

  logic [7:0] mode_one_r [2];
  logic [7:0] mode_two_r [2];
  logic       mode_ptr_r [2];
  logic [7:0] clk_sel_r  [2];
  logic [3:0] status_r   [2];
  logic [7:0] rx_buf_r   [2];
  logic [7:0] tx_buf_r   [2];
  logic       rx_act_r   [2];
  logic       tx_act_r   [2];
  logic [7:0] int_mask_r, int_vector_r;
  logic       irq_pending_r;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  cmd_t       cmd;
  logic       in_channel;
  logic [3:0] in_reg;
  logic [7:0] in_wdata, in_rxdata;
  logic       in_fire;
  logic       ch;
  logic [2:0] sub;
  logic       line_ok;
  logic [3:0] st_o;
  logic       ff_o;
  logic [7:0] int_status_cur;

  logic [7:0] mode_one_nxt, mode_two_nxt, clk_sel_nxt, rx_buf_nxt, tx_buf_nxt;
  logic       mode_ptr_nxt, rx_act_nxt, tx_act_nxt;
  logic [3:0] status_nxt;
  logic [7:0] int_mask_nxt, int_vector_nxt;
  logic       irq_pending_nxt;
  logic       irq_hit;

  logic [7:0]         rdata, txd, ackv;
  logic               txv, acc, dv;
  logic [DELAY_W-1:0] dly;

  assign cmd        = cmd_t'(in_tuser);
  assign in_channel = in_tdata[0];
  assign in_reg     = in_tdata[4:1];
  assign in_wdata   = in_tdata[12:5];
  assign in_rxdata  = in_tdata[20:13];

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign ch      = (cmd == CMD_READ || cmd == CMD_WRITE) ? in_reg[3] : in_channel;
  assign sub     = in_reg[2:0];
  assign line_ok = ch ? port_b_r : port_a_r;
  assign st_o    = status_r[~ch];
  assign ff_o    = mode_one_r[~ch][6];

  assign int_status_cur = int_status_f(ch, status_r[ch], mode_one_r[ch][6], st_o, ff_o);

  always_comb begin
    mode_one_nxt   = mode_one_r[ch];
    mode_two_nxt   = mode_two_r[ch];
    mode_ptr_nxt   = mode_ptr_r[ch];
    clk_sel_nxt    = clk_sel_r[ch];
    status_nxt     = status_r[ch];
    rx_buf_nxt     = rx_buf_r[ch];
    tx_buf_nxt     = tx_buf_r[ch];
    rx_act_nxt     = rx_act_r[ch];
    tx_act_nxt     = tx_act_r[ch];
    int_mask_nxt   = int_mask_r;
    int_vector_nxt = int_vector_r;
    irq_hit        = 1'b0;
    rdata = 8'h00;
    txv   = 1'b0;
    txd   = 8'h00;
    acc   = 1'b0;
    dv    = 1'b0;
    dly   = '0;
    ackv  = 8'h00;
    unique case (cmd)
      CMD_READ: begin
        if (in_reg == REG_ISR_IMR) begin
          rdata = int_status_cur;
        end else if (in_reg == REG_IVR) begin
          rdata = int_vector_r;
        end else begin
          unique case (sub)
            SUB_MODE: begin
              if (mode_ptr_r[ch]) begin
                mode_ptr_nxt = 1'b0;
                rdata = mode_one_r[ch];
              end else begin
                rdata = mode_two_r[ch];
              end
            end
            SUB_STATUS: rdata = {4'h0, status_r[ch]};
            SUB_BUFFER: begin
              status_nxt = status_nxt & ~ST_RX_BITS;
              irq_hit = irq_hit | (|(int_mask_r &
                        int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
              rdata = rx_buf_r[ch];
            end
            default: ;
          endcase
        end
      end
      CMD_WRITE: begin
        if (in_reg == REG_ISR_IMR) begin
          int_mask_nxt = in_wdata;
        end else if (in_reg == REG_IVR) begin
          int_vector_nxt = in_wdata;
        end else begin
          unique case (sub)
            SUB_MODE: begin
              if (mode_ptr_r[ch]) begin
                mode_ptr_nxt = 1'b0;
                mode_one_nxt = in_wdata;
                irq_hit = irq_hit | (|(int_mask_r &
                          int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
              end else begin
                mode_two_nxt = in_wdata;
              end
            end
            SUB_STATUS: clk_sel_nxt = in_wdata;
            SUB_COMMAND: begin
              unique case (in_wdata[6:4])
                MISC_RESET_PTR: mode_ptr_nxt = 1'b1;
                MISC_RESET_RX: begin
                  rx_act_nxt = 1'b0;
                  status_nxt = status_nxt & ~ST_RX_BITS;
                  irq_hit = irq_hit | (|(int_mask_r &
                            int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
                end
                MISC_RESET_TX: begin
                  tx_act_nxt = 1'b0;
                  status_nxt = status_nxt & ~ST_TX_BITS;
                  irq_hit = irq_hit | (|(int_mask_r &
                            int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
                end
                default: ;
              endcase
              unique case (in_wdata[3:2])
                XC_ENABLE: begin
                  tx_act_nxt = 1'b1;
                  status_nxt = status_nxt | ST_TX_BITS;
                  irq_hit = irq_hit | (|(int_mask_r &
                            int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
                end
                XC_DISABLE: begin
                  tx_act_nxt = 1'b0;
                  status_nxt = status_nxt & ~ST_TX_BITS;
                  irq_hit = irq_hit | (|(int_mask_r &
                            int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
                end
                default: ;
              endcase
              unique case (in_wdata[1:0])
                XC_ENABLE: begin
                  rx_act_nxt = 1'b1;
                  status_nxt = status_nxt & ~ST_RX_BITS;
                  irq_hit = irq_hit | (|(int_mask_r &
                            int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
                end
                XC_DISABLE: rx_act_nxt = 1'b0;
                default: ;
              endcase
            end
            SUB_BUFFER: begin
              tx_buf_nxt = in_wdata;
              status_nxt = status_nxt & ~ST_TX_BITS;
              irq_hit = irq_hit | (|(int_mask_r &
                        int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
              dv  = 1'b1;
              dly = baud_delay_f(baud_set_r, clk_sel_r[ch][3:0]);
            end
            default: ;
          endcase
        end
      end
      CMD_TX_DONE: begin
        irq_hit = |(int_mask_r & int_status_cur);
        if (!line_ok || tx_act_r[ch]) begin
          if (line_ok && mode_two_r[ch][7:6] != MODE_AUTO_ECHO) begin
            txv = 1'b1;
            txd = char_mask_f(mode_one_r[ch][1:0], tx_buf_r[ch]);
          end
          status_nxt = status_nxt | ST_TX_BITS;
          irq_hit = irq_hit | (|(int_mask_r &
                    int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
        end
      end
      CMD_RX_BYTE: begin
        irq_hit = |(int_mask_r & int_status_cur);
        dv = 1'b1;
        if (!rx_act_r[ch] || status_r[ch][1]) begin
          if (ch && status_r[ch][1]) begin
            dly = baud_delay_f(baud_set_r, clk_sel_r[ch][7:4]);
          end else begin
            dly = RX_RETRY_US;
          end
        end else begin
          acc = 1'b1;
          rx_buf_nxt = char_mask_f(mode_one_r[ch][1:0], in_rxdata);
          if (mode_two_r[ch][7:6] == MODE_AUTO_ECHO && line_ok) begin
            txv = 1'b1;
            txd = rx_buf_nxt;
          end
          status_nxt = status_nxt | ST_RX_BITS;
          irq_hit = irq_hit | (|(int_mask_r &
                    int_status_f(ch, status_nxt, mode_one_nxt[6], st_o, ff_o)));
          dly = baud_delay_f(baud_set_r, clk_sel_r[ch][7:4]);
        end
      end
      CMD_INT_ACK: begin
        ackv = irq_pending_r ? int_vector_r : SPURIOUS_VEC;
      end
      default: ;
    endcase
    if (cmd == CMD_INT_ACK) begin
      irq_pending_nxt = 1'b0;
    end else begin
      irq_pending_nxt = irq_pending_r | irq_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_level_r <= 3'd1;
      baud_set_r  <= 1'b0;
      port_a_r    <= 1'b1;
      port_b_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INT_LEVEL: int_level_r <= cfg_data[2:0];
        CFG_BAUD_SET:  baud_set_r  <= cfg_data[0];
        CFG_PORT_A:    port_a_r    <= cfg_data[0];
        CFG_PORT_B:    port_b_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        mode_one_r[i] <= 8'h00;
        mode_two_r[i] <= 8'h00;
        mode_ptr_r[i] <= 1'b1;
        clk_sel_r[i]  <= 8'h00;
        status_r[i]   <= 4'h0;
        rx_buf_r[i]   <= 8'h00;
        tx_buf_r[i]   <= 8'h00;
        rx_act_r[i]   <= 1'b0;
        tx_act_r[i]   <= 1'b0;
      end
      int_mask_r    <= 8'h00;
      int_vector_r  <= 8'h0f;
      irq_pending_r <= 1'b0;
    end else if (in_fire) begin
      mode_one_r[ch] <= mode_one_nxt;
      mode_two_r[ch] <= mode_two_nxt;
      mode_ptr_r[ch] <= mode_ptr_nxt;
      clk_sel_r[ch]  <= clk_sel_nxt;
      status_r[ch]   <= status_nxt;
      rx_buf_r[ch]   <= rx_buf_nxt;
      tx_buf_r[ch]   <= tx_buf_nxt;
      rx_act_r[ch]   <= rx_act_nxt;
      tx_act_r[ch]   <= tx_act_nxt;
      int_mask_r     <= int_mask_nxt;
      int_vector_r   <= int_vector_nxt;
      irq_pending_r  <= irq_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {2'b00, ackv, irq_pending_nxt, dly, dv, acc, txd, txv, rdata};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid_r)
    else $error("accepted item produced no result beat");

  a_ack_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cmd == CMD_INT_ACK) |=> !irq_pending_r && !out_tdata_r[37])
    else $error("interrupt acknowledge left the request pending");

  a_level_written: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == CFG_INT_LEVEL) |=>
      int_level_r == $past(cfg_data[2:0]))
    else $error("interrupt level register lost a write");

endmodule
